/* hw/rtl/cslc_pkg.sv */
// Shared types, constants and helper functions of the C source lexical classifier.
`default_nettype none

package cslc_pkg;

    // Token kinds as they appear on the result channel.
    typedef enum logic [2:0] {
        KIND_NUMBER  = 3'd0,
        KIND_KEYWORD = 3'd1,
        KIND_IDENT   = 3'd2,
        KIND_OPER    = 3'd3,
        KIND_SPECIAL = 3'd4,
        KIND_END     = 3'd5
    } t_kind;

    localparam int QUEUE_DEPTH = 4;
    localparam int KW_COUNT    = 11;

    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NEWLINE    = 8'h0a;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
    localparam logic [7:0] CH_DOLLAR     = 8'h24;

    // Keywords packed first character in the lowest byte, unused bytes zero.
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'h0000_0000_0072_6f66,   // for
        64'h0000_0065_6c69_6877,   // while
        64'h0000_0000_0000_6f64,   // do
        64'h0000_0000_0074_6e69,   // int
        64'h0000_0074_616f_6c66,   // float
        64'h0000_0000_7261_6863,   // char
        64'h0000_656c_6275_6f64,   // double
        64'h0000_6369_7461_7473,   // static
        64'h0000_6863_7469_7773,   // switch
        64'h0000_0000_6573_6163,   // case
        64'h0000_0000_6469_6f76    // void
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd5, 4'd2, 4'd3, 4'd5, 4'd4, 4'd6, 4'd6, 4'd6, 4'd4, 4'd4
    };

    // One queue entry: the token closed by a byte, then the token the byte makes itself.
    typedef struct packed {
        logic        has_first;
        logic        first_word;
        logic [31:0] num_value;
        logic        num_sat;
        logic [63:0] text;
        logic [3:0]  length;
        logic        truncated;
        logic        has_second;
        logic        second_end;
        logic        second_op;
        logic [7:0]  symbol;
        logic [31:0] lines;
    } t_cmd;

    typedef struct packed {
        t_kind       token_kind;
        logic [31:0] number_value;
        logic        number_saturated;
        logic [63:0] ident_text;
        logic [3:0]  ident_length;
        logic        ident_truncated;
        logic [3:0]  keyword_index;
        logic [7:0]  symbol_code;
        logic [31:0] line_count;
        logic        last_of_run;
    } t_token;

    typedef struct packed {
        logic       hit;
        logic [3:0] index;
    } t_kw_hit;

    function automatic t_kw_hit kw_lookup(logic [63:0] text, logic [3:0] len);
        t_kw_hit r;
        r = '0;
        // Walk backwards so the lowest matching index wins.
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (KW_TEXT[k] == text && KW_LEN[k] == len) begin
                r.hit   = 1'b1;
                r.index = 4'(k);
            end
        end
        return r;
    endfunction

    function automatic logic is_operator(logic [7:0] c);
        return c == "+" || c == "-" || c == "/" || c == "*" || c == "%" ||
               c == "<" || c == ">" || c == "=" || c == "!" || c == "&" ||
               c == "|";
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/cslc_if.sv */
// Valid/ready channel interfaces for the text byte input and the token output.
`default_nettype none

interface cslc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface cslc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [31:0] number_value;
    logic        number_saturated;
    logic [63:0] ident_text;
    logic [3:0]  ident_length;
    logic        ident_truncated;
    logic [3:0]  keyword_index;
    logic [7:0]  symbol_code;
    logic [31:0] line_count;
    logic        last_of_run;

    modport source (
        output valid, output token_kind, output number_value, output number_saturated,
        output ident_text, output ident_length, output ident_truncated,
        output keyword_index, output symbol_code, output line_count, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input token_kind, input number_value, input number_saturated,
        input ident_text, input ident_length, input ident_truncated,
        input keyword_index, input symbol_code, input line_count, input last_of_run,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/cslc_front.sv */
// Front end: accepts bytes, tracks the open token and queues token commands.
`default_nettype none

module cslc_front #(
    parameter int MAX_IDENT_CHARS = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    cslc_in_if.sink            i_byte,
    input  wire logic          i_q_full,
    output logic               o_push,
    output cslc_pkg::t_cmd     o_cmd
);

    localparam int IDX_W = (MAX_IDENT_CHARS > 1) ? $clog2(MAX_IDENT_CHARS) : 1;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_NUM  = 3'b010,
        MODE_WORD = 3'b100
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [31:0] r_acc, n_acc;
    logic        r_clamp, n_clamp;
    logic [3:0]  r_count, n_count;
    logic        r_ovf, n_ovf;
    logic [31:0] r_lines, n_lines;
    logic [7:0]  r_buf [MAX_IDENT_CHARS];

    logic             buf_we;
    logic [IDX_W-1:0] buf_idx;
    logic             accept;
    logic [7:0]       c;
    logic             is_digit, is_letter, word_cont;
    logic [35:0]      acc_next;
    logic [63:0]      packed_text;

    assign i_byte.ready = !i_q_full;
    assign accept       = i_byte.valid && !i_q_full;
    assign c            = i_byte.char_code;
    assign is_digit     = (c >= cslc_pkg::CH_ZERO) && (c <= cslc_pkg::CH_NINE);
    assign is_letter    = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    assign word_cont    = is_letter || is_digit ||
                          c == cslc_pkg::CH_UNDERSCORE || c == cslc_pkg::CH_DOLLAR;
    // acc * 10 + digit as acc * 8 + acc * 2 + digit.
    assign acc_next     = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {32'd0, c[3:0]};

    always_comb begin
        packed_text = '0;
        for (int i = 0; i < MAX_IDENT_CHARS; i++) begin
            if (4'(i) < r_count) begin
                packed_text[8*i +: 8] = r_buf[i];
            end
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_acc   = r_acc;
        n_clamp = r_clamp;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_lines = r_lines;
        buf_we  = 1'b0;
        buf_idx = r_count[IDX_W-1:0];
        o_push  = 1'b0;

        o_cmd            = '0;
        o_cmd.first_word = (r_mode == MODE_WORD);
        o_cmd.num_value  = r_acc;
        o_cmd.num_sat    = r_clamp;
        o_cmd.text       = packed_text;
        o_cmd.length     = r_count;
        o_cmd.truncated  = r_ovf;
        o_cmd.symbol     = c;
        o_cmd.second_op  = cslc_pkg::is_operator(c);
        o_cmd.lines      = r_lines;

        if (accept) begin
            if (i_byte.end_of_text) begin
                o_cmd.has_first  = (r_mode != MODE_IDLE);
                o_cmd.has_second = 1'b1;
                o_cmd.second_end = 1'b1;
                o_push  = 1'b1;
                n_mode  = MODE_IDLE;
                n_acc   = '0;
                n_clamp = 1'b0;
                n_count = '0;
                n_ovf   = 1'b0;
                n_lines = '0;
            end else if (r_mode == MODE_NUM && is_digit) begin
                if (r_clamp || acc_next[35:32] != 4'd0) begin
                    n_acc   = '1;
                    n_clamp = 1'b1;
                end else begin
                    n_acc = acc_next[31:0];
                end
            end else if (r_mode == MODE_WORD && word_cont) begin
                if (r_count < 4'(MAX_IDENT_CHARS)) begin
                    buf_we  = 1'b1;
                    n_count = r_count + 4'd1;
                end else begin
                    n_ovf = 1'b1;
                end
            end else begin
                // The open token closes and the byte is classified afresh.
                o_cmd.has_first = (r_mode != MODE_IDLE);
                n_mode = MODE_IDLE;
                if (is_digit) begin
                    n_mode  = MODE_NUM;
                    n_acc   = {28'd0, c[3:0]};
                    n_clamp = 1'b0;
                end else if (is_letter) begin
                    n_mode  = MODE_WORD;
                    buf_we  = 1'b1;
                    buf_idx = '0;
                    n_count = 4'd1;
                    n_ovf   = 1'b0;
                end else if (c == cslc_pkg::CH_SPACE || c == cslc_pkg::CH_TAB) begin
                    n_mode = MODE_IDLE;
                end else if (c == cslc_pkg::CH_NEWLINE) begin
                    if (r_lines != '1) begin
                        n_lines = r_lines + 32'd1;
                    end
                end else begin
                    o_cmd.has_second = 1'b1;
                end
                o_push = o_cmd.has_first || o_cmd.has_second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_acc   <= '0;
            r_clamp <= 1'b0;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_lines <= '0;
        end else begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_clamp <= n_clamp;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_lines <= n_lines;
        end
    end

    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            r_buf[buf_idx] <= c;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/cslc_queue.sv */
// Short command queue between the front end and the token emitter.
`default_nettype none

module cslc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire cslc_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output cslc_pkg::t_cmd      o_head
);

    localparam int DEPTH = cslc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    cslc_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == (PTR_W + 1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (PTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (PTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/cslc_back.sv */
// Back end: splits queued commands into tokens, matches keywords, holds the output register.
`default_nettype none

module cslc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire cslc_pkg::t_cmd i_head,
    output logic                o_pop,
    cslc_out_if.source          o_token
);

    cslc_pkg::t_token  r_tok, n_tok;
    logic              r_valid;
    logic              r_phase;
    logic              load;
    logic              sel_second;
    logic              last;
    cslc_pkg::t_kw_hit kw;

    assign load       = !i_empty && (!r_valid || o_token.ready);
    assign sel_second = r_phase || !i_head.has_first;
    assign last       = sel_second || !i_head.has_second;
    assign o_pop      = load && last;
    assign kw         = cslc_pkg::kw_lookup(i_head.text, i_head.length);

    always_comb begin
        n_tok             = '0;
        n_tok.last_of_run = last;
        if (sel_second) begin
            if (i_head.second_end) begin
                n_tok.token_kind = cslc_pkg::KIND_END;
                n_tok.line_count = i_head.lines;
            end else begin
                n_tok.token_kind  = i_head.second_op ? cslc_pkg::KIND_OPER
                                                     : cslc_pkg::KIND_SPECIAL;
                n_tok.symbol_code = i_head.symbol;
            end
        end else if (i_head.first_word) begin
            // A truncated word is never a keyword.
            n_tok.ident_text      = i_head.text;
            n_tok.ident_length    = i_head.length;
            n_tok.ident_truncated = i_head.truncated;
            if (kw.hit && !i_head.truncated) begin
                n_tok.token_kind    = cslc_pkg::KIND_KEYWORD;
                n_tok.keyword_index = kw.index;
            end else begin
                n_tok.token_kind = cslc_pkg::KIND_IDENT;
            end
        end else begin
            n_tok.token_kind       = cslc_pkg::KIND_NUMBER;
            n_tok.number_value     = i_head.num_value;
            n_tok.number_saturated = i_head.num_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= !last;
            end else if (o_token.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok <= n_tok;
        end
    end

    assign o_token.valid            = r_valid;
    assign o_token.token_kind       = r_tok.token_kind;
    assign o_token.number_value     = r_tok.number_value;
    assign o_token.number_saturated = r_tok.number_saturated;
    assign o_token.ident_text       = r_tok.ident_text;
    assign o_token.ident_length     = r_tok.ident_length;
    assign o_token.ident_truncated  = r_tok.ident_truncated;
    assign o_token.keyword_index    = r_tok.keyword_index;
    assign o_token.symbol_code      = r_tok.symbol_code;
    assign o_token.line_count       = r_tok.line_count;
    assign o_token.last_of_run      = r_tok.last_of_run;

endmodule

`default_nettype wire

/* hw/rtl/c_source_lexical_classifier.sv */
// Top level of the C source lexical classifier: front end, command queue and token emitter.
// A token closed by an accepted byte goes through the command queue and the output register.
// Throughput: one byte per cycle while the queue is not full; the single output register
// gives one token per cycle while ready, so a byte closing a token and making one sends two.
// Reset: synchronous, active low; clears scan state, counters, queue and output valid.
// The identifier buffer is not cleared.
`default_nettype none

module c_source_lexical_classifier #(
    parameter int MAX_IDENT_CHARS = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cslc_in_if.sink    i_byte,
    cslc_out_if.source o_token
);

    logic           q_full;
    logic           q_empty;
    logic           push;
    logic           pop;
    cslc_pkg::t_cmd push_cmd;
    cslc_pkg::t_cmd head_cmd;

    cslc_front #(
        .MAX_IDENT_CHARS(MAX_IDENT_CHARS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    cslc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    cslc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head_cmd),
        .o_pop   (pop),
        .o_token (o_token)
    );

endmodule

`default_nettype wire

/* tb/c_source_lexical_classifier_tb.sv */
// Self-checking testbench for the C source lexical classifier: text bytes in, tokens out.
`default_nettype none

module c_source_lexical_classifier_tb;

    localparam int IDENT_CAP   = 8;
    localparam int KEYWORDS    = 11;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [1:0] {
        SCAN_IDLE   = 2'd0,
        SCAN_NUMBER = 2'd1,
        SCAN_WORD   = 2'd2
    } t_scan;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } t_text_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cslc_in_if  byte_ch ();
    cslc_out_if token_ch ();

    c_source_lexical_classifier #(
        .MAX_IDENT_CHARS(IDENT_CAP)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_byte (byte_ch),
        .o_token(token_ch)
    );

    always #4 i_clk = ~i_clk;

    string kw_names [KEYWORDS] = '{
        "for", "while", "do", "int", "float", "char",
        "double", "static", "switch", "case", "void"
    };
    string op_chars = "+-/*%<>=!&|";

    // Scanner state of the predictor.
    t_scan       scan_state;
    logic [31:0] num_acc;
    logic        num_clamped;
    logic [7:0]  word_buf [IDENT_CAP];
    logic [3:0]  word_len;
    logic        word_over;
    logic [31:0] lines_seen;

    t_text_item         text_queue [$];
    cslc_pkg::t_token   tokens_due [$];
    cslc_pkg::t_token   step_tokens [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_made    = 0;
    int bytes_taken   = 0;
    int tokens_seen   = 0;
    int mismatches    = 0;
    int cycle_count   = 0;
    int hold_left     = 0;
    bit long_hold_done = 1'b0;
    int kind_tally [6];

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_op_char(logic [7:0] c);
        bit hit;
        hit = 1'b0;
        for (int i = 0; i < op_chars.len(); i++)
            if (c == op_chars[i]) hit = 1'b1;
        return hit;
    endfunction

    task automatic clear_scan();
        scan_state  = SCAN_IDLE;
        num_acc     = '0;
        num_clamped = 1'b0;
        word_len    = '0;
        word_over   = 1'b0;
        lines_seen  = '0;
    endtask

    // Emits the number or word in progress, if any.
    task automatic close_token();
        cslc_pkg::t_token t;
        int     kw;
        bit     same;
        t  = '0;
        kw = -1;
        if (scan_state == SCAN_NUMBER) begin
            t.token_kind       = cslc_pkg::KIND_NUMBER;
            t.number_value     = num_acc;
            t.number_saturated = num_clamped;
            step_tokens.push_back(t);
        end else if (scan_state == SCAN_WORD) begin
            for (int i = 0; i < word_len; i++)
                t.ident_text[8*i +: 8] = word_buf[i];
            if (!word_over) begin
                for (int k = 0; k < KEYWORDS; k++) begin
                    same = (kw_names[k].len() == word_len);
                    for (int i = 0; i < word_len && same; i++)
                        if (kw_names[k][i] != word_buf[i]) same = 1'b0;
                    if (same && kw < 0) kw = k;
                end
            end
            t.token_kind      = (kw >= 0) ? cslc_pkg::KIND_KEYWORD : cslc_pkg::KIND_IDENT;
            t.ident_length    = word_len;
            t.ident_truncated = word_over;
            t.keyword_index   = (kw >= 0) ? 4'(kw) : 4'd0;
            step_tokens.push_back(t);
        end
        scan_state = SCAN_IDLE;
    endtask

    task automatic start_token(input logic [7:0] c);
        cslc_pkg::t_token t;
        t = '0;
        if (is_digit(c)) begin
            scan_state  = SCAN_NUMBER;
            num_acc     = 32'(c - cslc_pkg::CH_ZERO);
            num_clamped = 1'b0;
        end else if (is_letter(c)) begin
            scan_state  = SCAN_WORD;
            word_buf[0] = c;
            word_len    = 4'd1;
            word_over   = 1'b0;
        end else if (c == cslc_pkg::CH_NEWLINE) begin
            if (lines_seen != 32'hFFFF_FFFF) lines_seen++;
        end else if (c != cslc_pkg::CH_SPACE && c != cslc_pkg::CH_TAB) begin
            t.token_kind  = is_op_char(c) ? cslc_pkg::KIND_OPER : cslc_pkg::KIND_SPECIAL;
            t.symbol_code = c;
            step_tokens.push_back(t);
        end
    endtask

    // Advances the predictor by one accepted request and queues the tokens it yields.
    task automatic classify_byte(input logic [7:0] c, input logic eot);
        cslc_pkg::t_token t;
        logic [63:0] grown;
        step_tokens = {};
        if (eot) begin
            close_token();
            t            = '0;
            t.token_kind = cslc_pkg::KIND_END;
            t.line_count = lines_seen;
            step_tokens.push_back(t);
            clear_scan();
        end else if (scan_state == SCAN_NUMBER && is_digit(c)) begin
            grown = 64'(num_acc) * 64'd10 + 64'(c - cslc_pkg::CH_ZERO);
            if (num_clamped || grown > 64'hFFFF_FFFF) begin
                num_acc     = 32'hFFFF_FFFF;
                num_clamped = 1'b1;
            end else begin
                num_acc = grown[31:0];
            end
        end else if (scan_state == SCAN_WORD && (is_letter(c) || is_digit(c) ||
                     c == cslc_pkg::CH_UNDERSCORE || c == cslc_pkg::CH_DOLLAR)) begin
            if (word_len < IDENT_CAP) begin
                word_buf[word_len] = c;
                word_len++;
            end else begin
                word_over = 1'b1;
            end
        end else begin
            close_token();
            start_token(c);
        end
        for (int i = 0; i < step_tokens.size(); i++) begin
            t = step_tokens[i];
            t.last_of_run = (i == step_tokens.size() - 1);
            tokens_due.push_back(t);
        end
    endtask

    task automatic push_byte(input logic [7:0] c, input logic eot);
        t_text_item it;
        it.ch  = c;
        it.eot = eot;
        text_queue.push_back(it);
        items_made++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], 1'b0);
    endtask

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(51);
        return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] rand_word_char();
        int r;
        r = $urandom_range(63);
        if (r < 52) return rand_letter();
        if (r < 62) return 8'("0" + r - 52);
        return (r == 62) ? cslc_pkg::CH_UNDERSCORE : cslc_pkg::CH_DOLLAR;
    endfunction

    // Mostly keeps words and numbers apart so that keywords survive.
    task automatic push_separator();
        case ($urandom_range(9))
            0, 1, 2, 3: push_byte(cslc_pkg::CH_SPACE, 1'b0);
            4:          push_byte(cslc_pkg::CH_NEWLINE, 1'b0);
            5, 6:       push_byte(op_chars[$urandom_range(10)], 1'b0);
            default:    ;
        endcase
    endtask

    task automatic push_fragment();
        int sel;
        int n;
        sel = $urandom_range(99);
        if (sel < 20) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                push_byte(8'("0" + $urandom_range(9)), 1'b0);
            push_separator();
        end else if (sel < 40) begin
            push_text(kw_names[$urandom_range(KEYWORDS - 1)]);
            if ($urandom_range(4) == 0) push_byte(rand_word_char(), 1'b0);
            push_separator();
        end else if (sel < 55) begin
            push_byte(rand_letter(), 1'b0);
            n = $urandom_range(11);
            for (int i = 0; i < n; i++)
                push_byte(rand_word_char(), 1'b0);
            push_separator();
        end else if (sel < 68) begin
            push_byte(op_chars[$urandom_range(10)], 1'b0);
        end else if (sel < 78) begin
            case ($urandom_range(2))
                0:       push_byte(cslc_pkg::CH_SPACE, 1'b0);
                1:       push_byte(cslc_pkg::CH_TAB, 1'b0);
                default: push_byte(cslc_pkg::CH_NEWLINE, 1'b0);
            endcase
        end else if (sel < 90) begin
            push_byte(8'($urandom_range(255)), 1'b0);
        end else if (sel < 94) begin
            push_byte(8'($urandom_range(255)), 1'b1);
        end else begin
            // A number running straight into a word.
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                push_byte(8'("0" + $urandom_range(9)), 1'b0);
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                push_byte(rand_letter(), 1'b0);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (text_queue.size() > 0 || byte_ch.valid || tokens_due.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Request driver: holds a request until it is taken, then offers the next one.
    always @(posedge i_clk) begin : driver
        t_text_item nxt;
        if (!i_rst_n) begin
            byte_ch.valid       <= 1'b0;
            byte_ch.char_code   <= '0;
            byte_ch.end_of_text <= 1'b0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                classify_byte(byte_ch.char_code, byte_ch.end_of_text);
                bytes_taken++;
            end
            if (!byte_ch.valid || byte_ch.ready) begin
                if (text_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = text_queue.pop_front();
                    byte_ch.valid       <= 1'b1;
                    byte_ch.char_code   <= nxt.ch;
                    byte_ch.end_of_text <= nxt.eot;
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Token monitor and output backpressure.
    always @(posedge i_clk) begin : monitor
        cslc_pkg::t_token want;
        if (!i_rst_n) begin
            token_ch.ready <= 1'b0;
        end else begin
            if (token_ch.valid && token_ch.ready) begin
                tokens_seen++;
                if (token_ch.token_kind < 3'd6) kind_tally[token_ch.token_kind]++;
                if (tokens_due.size() == 0) begin
                    $error("token of kind %0d arrived with none expected",
                           token_ch.token_kind);
                    mismatches++;
                end else begin
                    want = tokens_due.pop_front();
                    check_field("token_kind", want.token_kind, token_ch.token_kind);
                    check_field("number_value", want.number_value, token_ch.number_value);
                    check_field("number_saturated", want.number_saturated,
                                token_ch.number_saturated);
                    check_field("ident_text", want.ident_text, token_ch.ident_text);
                    check_field("ident_length", want.ident_length, token_ch.ident_length);
                    check_field("ident_truncated", want.ident_truncated,
                                token_ch.ident_truncated);
                    check_field("keyword_index", want.keyword_index, token_ch.keyword_index);
                    check_field("symbol_code", want.symbol_code, token_ch.symbol_code);
                    check_field("line_count", want.line_count, token_ch.line_count);
                    check_field("last_of_run", want.last_of_run, token_ch.last_of_run);
                end
            end
            // One long hold-off early on lets the command queue fill and stall the input.
            if (hold_left > 0) begin
                hold_left--;
                token_ch.ready <= 1'b0;
            end else if (!long_hold_done && tokens_seen >= 150) begin
                long_hold_done = 1'b1;
                hold_left      = 150;
                token_ch.ready <= 1'b0;
            end else begin
                token_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d tokens outstanding",
                     cycle_count, tokens_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        byte_ch.valid        = 1'b0;
        byte_ch.char_code    = '0;
        byte_ch.end_of_text  = 1'b0;
        token_ch.ready       = 1'b0;
        foreach (kind_tally[k]) kind_tally[k] = 0;
        clear_scan();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        send_idle_pct = 10;
        recv_idle_pct = 54;
        // Saturating number closed by a letter, a truncated word closed by an operator,
        // odd bytes, then a number closed by the end marker.
        push_text("4294967296zY_$09ab7*");
        push_byte(8'h0d, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(cslc_pkg::CH_TAB, 1'b0);
        push_byte(cslc_pkg::CH_NEWLINE, 1'b0);
        push_byte("7", 1'b0);
        push_byte(8'hff, 1'b1);
        while (items_made < 640) push_fragment();
        wait_drained();

        send_idle_pct = 54;
        recv_idle_pct = 10;
        while (items_made < 1280) push_fragment();
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (items_made < 1900) push_fragment();
        push_byte(8'h00, 1'b1);
        wait_drained();
        repeat (8) @(negedge i_clk);

        $display("Sent %0d text bytes over three idle patterns; checked %0d tokens.",
                 bytes_taken, tokens_seen);
        $display("Numbers %0d, keywords %0d, identifiers %0d, operators %0d,",
                 kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3]);
        $display("special %0d, ends %0d.", kind_tally[4], kind_tally[5]);
        if (mismatches == 0 && tokens_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
